### src/assert_macros.svh
// Assertion macros used by the verification file of the merge filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define SRMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

### src/srmf_pkg.sv
// Package with the shared types, codes and widths of the sorted-run merge filter.
package srmf_pkg;

	localparam int RUN_CAPACITY_DEF = 16;
	localparam int REF_WIDTH_DEF = 16;
	localparam int REQ_W = 2;
	localparam int KEY_W = 32;
	localparam int VER_W = 32;
	localparam int CMD_DEPTH = 2;

	localparam logic [REQ_W-1:0] REQ_LOAD_LEFT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_RIGHT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MERGE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD_LEFT,
		OP_LOAD_RIGHT,
		OP_MERGE
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_ctl_t;

endpackage

### src/sorted_run_merge_filter_core.sv
// Top level of the sorted-run merge filter: front end, command queue and merge back end.
//
//   channel   direction  handshake          fields
//   request   in         push / full        req_type item_ref sort_key stored_version
//                                           current_version
//   result    out        pop / empty        out_ref out_key out_version out_valid
//                                           out_last overflow
//
// A load is written when the back end takes it; a merge gives one result per cycle unless
// stalled, as each run memory has a single read port feeding its head register.
// The front end holds up to two queued items and raises full when both slots are taken.
// Reset clears the counts, the overflow flag and the queues; the run memories are not cleared.
// A result waiting in the output register stalls the merge until it is popped.
module sorted_run_merge_filter_core #(
	parameter int RUN_CAPACITY = srmf_pkg::RUN_CAPACITY_DEF,
	parameter int REF_WIDTH = srmf_pkg::REF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [srmf_pkg::REQ_W-1:0]     req_type,
	input  logic [REF_WIDTH-1:0]           item_ref,
	input  logic [srmf_pkg::KEY_W-1:0]     sort_key,
	input  logic [srmf_pkg::VER_W-1:0]     stored_version,
	input  logic [srmf_pkg::VER_W-1:0]     current_version,
	output logic                           empty,
	input  logic                           pop,
	output logic [REF_WIDTH-1:0]           out_ref,
	output logic [srmf_pkg::KEY_W-1:0]     out_key,
	output logic [srmf_pkg::VER_W-1:0]     out_version,
	output logic                           out_valid,
	output logic                           out_last,
	output logic                           overflow
);
	import srmf_pkg::*;

	localparam int EW = REF_WIDTH + KEY_W + VER_W;

	cmd_ctl_t         cmd;
	logic [EW-1:0]    cmd_data;
	logic             cmd_take;

	srmf_front #(
		.REF_WIDTH(REF_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.item_ref(item_ref),
		.sort_key(sort_key),
		.stored_version(stored_version),
		.current_version(current_version),
		.cmd(cmd),
		.cmd_data(cmd_data),
		.cmd_take(cmd_take)
	);

	srmf_back #(
		.RUN_CAPACITY(RUN_CAPACITY),
		.REF_WIDTH(REF_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_data(cmd_data),
		.cmd_take(cmd_take),
		.empty(empty),
		.pop(pop),
		.out_ref(out_ref),
		.out_key(out_key),
		.out_version(out_version),
		.out_valid(out_valid),
		.out_last(out_last),
		.overflow(overflow)
	);

endmodule

### src/srmf_front.sv
// Front end: accepts items, discards unowned loads and unused request codes and queues the rest for the back end.
module srmf_front #(
	parameter int REF_WIDTH = srmf_pkg::REF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [srmf_pkg::REQ_W-1:0]     req_type,
	input  logic [REF_WIDTH-1:0]           item_ref,
	input  logic [srmf_pkg::KEY_W-1:0]     sort_key,
	input  logic [srmf_pkg::VER_W-1:0]     stored_version,
	input  logic [srmf_pkg::VER_W-1:0]     current_version,
	output srmf_pkg::cmd_ctl_t             cmd,
	output logic [REF_WIDTH+srmf_pkg::KEY_W+srmf_pkg::VER_W-1:0] cmd_data,
	input  logic                           cmd_take
);
	import srmf_pkg::*;

	localparam int EW = REF_WIDTH + KEY_W + VER_W;
	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int NW = $clog2(CMD_DEPTH + 1);
	localparam logic [NW-1:0] DEPTH_N = NW'(CMD_DEPTH);

	op_t              op_q [CMD_DEPTH];
	logic [EW-1:0]    data_q [CMD_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	op_t              op_in;
	logic             keep;
	logic             wr_en;
	logic             rd_en;

	always_comb begin
		op_in = OP_MERGE;
		keep = 1'b0;
		unique case (req_type)
			REQ_LOAD_LEFT: begin
				op_in = OP_LOAD_LEFT;
				keep = (item_ref != '0) && (stored_version == current_version);
			end
			REQ_LOAD_RIGHT: begin
				op_in = OP_LOAD_RIGHT;
				keep = (item_ref != '0) && (stored_version == current_version);
			end
			REQ_MERGE: begin
				op_in = OP_MERGE;
				keep = 1'b1;
			end
			REQ_UNUSED: begin
				op_in = OP_MERGE;
				keep = 1'b0;
			end
		endcase
	end

	assign full = (count_q == DEPTH_N);
	assign wr_en = push && !full && keep;
	assign rd_en = cmd_take && (count_q != '0);

	assign cmd.valid = (count_q != '0);
	assign cmd.op = op_q[rd_ptr_q];
	assign cmd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			op_q[wr_ptr_q] <= op_in;
			data_q[wr_ptr_q] <= {item_ref, sort_key, stored_version};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/srmf_back.sv
// Back end: holds both runs, carries out loads and walks the merge into the result register.
module srmf_back #(
	parameter int RUN_CAPACITY = srmf_pkg::RUN_CAPACITY_DEF,
	parameter int REF_WIDTH = srmf_pkg::REF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srmf_pkg::cmd_ctl_t             cmd,
	input  logic [REF_WIDTH+srmf_pkg::KEY_W+srmf_pkg::VER_W-1:0] cmd_data,
	output logic                           cmd_take,
	output logic                           empty,
	input  logic                           pop,
	output logic [REF_WIDTH-1:0]           out_ref,
	output logic [srmf_pkg::KEY_W-1:0]     out_key,
	output logic [srmf_pkg::VER_W-1:0]     out_version,
	output logic                           out_valid,
	output logic                           out_last,
	output logic                           overflow
);
	import srmf_pkg::*;

	localparam int EW = REF_WIDTH + KEY_W + VER_W;
	localparam int AW = (RUN_CAPACITY > 1) ? $clog2(RUN_CAPACITY) : 1;
	localparam int CW = $clog2(RUN_CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(RUN_CAPACITY);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_MERGE = 1'b1;

	logic [EW-1:0]    lmem [RUN_CAPACITY];
	logic [EW-1:0]    rmem [RUN_CAPACITY];
	logic [EW-1:0]    lhead_q;
	logic [EW-1:0]    rhead_q;
	logic             state_q;
	logic [CW-1:0]    lcnt_q;
	logic [CW-1:0]    rcnt_q;
	logic [CW-1:0]    lidx_q;
	logic [CW-1:0]    ridx_q;
	logic             ovf_q;
	logic             out_full_q;

	logic             space;
	logic             emit;
	logic             l_more;
	logic             r_more;
	logic             take_left;
	logic             no_elems;
	logic             last;
	logic [CW-1:0]    lidx_n;
	logic [CW-1:0]    ridx_n;
	logic [CW-1:0]    lidx_d;
	logic [CW-1:0]    ridx_d;
	logic [AW-1:0]    lra;
	logic [AW-1:0]    rra;
	logic             wr_l;
	logic             wr_r;
	logic [EW-1:0]    sel;

	assign space = !out_full_q || pop;
	assign emit = (state_q == ST_MERGE) && space;
	assign cmd_take = (state_q == ST_IDLE) && cmd.valid;
	assign wr_l = cmd_take && (cmd.op == OP_LOAD_LEFT) && (lcnt_q < CAP);
	assign wr_r = cmd_take && (cmd.op == OP_LOAD_RIGHT) && (rcnt_q < CAP);

	assign l_more = (lidx_q < lcnt_q);
	assign r_more = (ridx_q < rcnt_q);
	assign take_left = l_more && (!r_more ||
		(lhead_q[VER_W +: KEY_W] < rhead_q[VER_W +: KEY_W]));
	assign no_elems = (lcnt_q == '0) && (rcnt_q == '0);
	assign lidx_n = lidx_q + CW'(take_left);
	assign ridx_n = ridx_q + CW'(!take_left);
	assign last = no_elems || ((lidx_n == lcnt_q) && (ridx_n == rcnt_q));
	assign lidx_d = emit ? (last ? '0 : lidx_n) : lidx_q;
	assign ridx_d = emit ? (last ? '0 : ridx_n) : ridx_q;
	assign lra = (lidx_d < CAP) ? lidx_d[AW-1:0] : '0;
	assign rra = (ridx_d < CAP) ? ridx_d[AW-1:0] : '0;
	assign sel = take_left ? lhead_q : rhead_q;

	always_ff @(posedge clk) begin
		if (wr_l) begin
			lmem[lcnt_q[AW-1:0]] <= cmd_data;
		end
		if (wr_r) begin
			rmem[rcnt_q[AW-1:0]] <= cmd_data;
		end
		lhead_q <= lmem[lra];
		rhead_q <= rmem[rra];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_ref <= no_elems ? '0 : sel[KEY_W + VER_W +: REF_WIDTH];
			out_key <= no_elems ? '0 : sel[VER_W +: KEY_W];
			out_version <= no_elems ? '0 : sel[VER_W-1:0];
			out_valid <= !no_elems;
			out_last <= last;
			overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lcnt_q <= '0;
			rcnt_q <= '0;
			lidx_q <= '0;
			ridx_q <= '0;
			ovf_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			lidx_q <= lidx_d;
			ridx_q <= ridx_d;
			if (emit) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						unique case (cmd.op)
							OP_LOAD_LEFT: begin
								if (wr_l) begin
									lcnt_q <= lcnt_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_LOAD_RIGHT: begin
								if (wr_r) begin
									rcnt_q <= rcnt_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_MERGE: begin
								state_q <= ST_MERGE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MERGE: begin
					if (emit && last) begin
						state_q <= ST_IDLE;
						lcnt_q <= '0;
						rcnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty = !out_full_q;

endmodule

### src/srmf_props.sv
// Port-level properties of the merge filter and the bind that attaches them to the top level.
`include "assert_macros.svh"

module srmf_props #(
	parameter int REF_WIDTH = srmf_pkg::REF_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           empty,
	input logic                           pop,
	input logic [REF_WIDTH-1:0]           out_ref,
	input logic [srmf_pkg::KEY_W-1:0]     out_key,
	input logic [srmf_pkg::VER_W-1:0]     out_version,
	input logic                           out_valid,
	input logic                           out_last,
	input logic                           overflow
);
	import srmf_pkg::*;

	`SRMF_ASSERT_SAME(a_marker_is_last, clk, arst_n, !empty && !out_valid, out_last)
	`SRMF_ASSERT_SAME(a_marker_is_zero, clk, arst_n, !empty && !out_valid, out_ref == '0 && out_key == '0 && out_version == '0)
	`SRMF_ASSERT_NEXT(a_stall_holds, clk, arst_n, !empty && !pop, !empty && $stable(out_key) && $stable(out_last))
	`SRMF_ASSERT_NEXT(a_merge_streams, clk, arst_n, !empty && pop && !out_last, !empty && out_valid && $stable(overflow))

endmodule

bind sorted_run_merge_filter_core srmf_props #(.REF_WIDTH(REF_WIDTH)) u_props (.*);
